>>> rtl/rfpa_pkg.sv
// ----------------------------------------------------------------------------
// rfpa_pkg
// Shared constants, types and helper functions of the range flip popcount
// accumulator.
// ----------------------------------------------------------------------------
package rfpa_pkg;

    localparam int ARRAY_BITS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (ARRAY_BITS + WORD_BITS - 1) / WORD_BITS;

    localparam int KIND_W   = 3;
    localparam int IDX_W    = 10;
    localparam int AMT_W    = 30;
    localparam int TOTAL_W  = 64;

    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int WADDR_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int COUNT_W  = $clog2(ARRAY_BITS + 1);
    localparam int PROD_W   = COUNT_W + AMT_W;
    localparam int ARRAY_W  = $clog2(ARRAY_BITS + 1);
    localparam int CMP_W    = ((IDX_W > ARRAY_W) ? IDX_W : ARRAY_W) + 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [BIT_W-1:0]     bitpos_t;
    typedef logic [BIT_W:0]       wcount_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 3'd0,
        KIND_FLIP   = 3'd1,
        KIND_MUL    = 3'd2,
        KIND_REPORT = 3'd3,
        KIND_ADD    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_FLIP_FIRST,
        S_FLIP,
        S_FLIP_LAST,
        S_ADD
    } state_t;

    typedef struct packed {
        logic latch;
        logic add_amount;
        logic report;
        logic mul_capture;
        logic mul_add;
        logic load_rd;
        logic load_wr;
        logic flip_rd;
        logic flip_wr;
    } cmd_t;

    typedef struct packed {
        logic load_ok;
        logic flip_ok;
        logic at_last;
        logic rsp_blocked;
    } stat_t;

    function automatic waddr_t word_of(input idx_t idx);
        idx_t q;
        q = idx >> BIT_W;
        return waddr_t'(q);
    endfunction

    function automatic wcount_t pop_word(input word_t w);
        wcount_t n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + wcount_t'(w[i]);
        end
        return n;
    endfunction

endpackage

>>> rtl/rfpa_ram.sv
// ----------------------------------------------------------------------------
// rfpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rfpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/rfpa_ctrl.sv
// ----------------------------------------------------------------------------
// rfpa_ctrl
// Request sequencer: accepts words, walks loads and range flips through the
// bit store and orders the two-step multiply-accumulate.
// ----------------------------------------------------------------------------
module rfpa_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic [rfpa_pkg::KIND_W-1:0]    kind,
    output logic                           req_stall,
    input  rfpa_pkg::stat_t                stat,
    output rfpa_pkg::cmd_t                 cmd
);
    import rfpa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    kind_t  req_kind;

    assign req_kind  = kind_t'(kind);
    assign req_stall = (state_reg != S_IDLE) || ((req_kind == KIND_REPORT) && stat.rsp_blocked);
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_kind)
                        KIND_LOAD:
                        begin
                            if (stat.load_ok)
                            begin
                                state_next = S_LOAD_RD;
                            end
                        end
                        KIND_FLIP:
                        begin
                            if (stat.flip_ok)
                            begin
                                state_next = S_FLIP_FIRST;
                            end
                        end
                        KIND_MUL:
                        begin
                            state_next = S_ADD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD_RD:    state_next = S_LOAD_WR;
            S_LOAD_WR:    state_next = S_IDLE;
            S_FLIP_FIRST: state_next = stat.at_last ? S_FLIP_LAST : S_FLIP;
            S_FLIP:       state_next = stat.at_last ? S_FLIP_LAST : S_FLIP;
            S_FLIP_LAST:  state_next = S_IDLE;
            S_ADD:        state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.latch       = accept;
        cmd.add_amount  = accept && (req_kind == KIND_ADD);
        cmd.report      = accept && (req_kind == KIND_REPORT);
        cmd.mul_capture = accept && (req_kind == KIND_MUL);
        case (state_reg)
            S_LOAD_RD:    cmd.load_rd = 1'b1;
            S_LOAD_WR:    cmd.load_wr = 1'b1;
            S_FLIP_FIRST: cmd.flip_rd = 1'b1;
            S_FLIP:
            begin
                cmd.flip_rd = 1'b1;
                cmd.flip_wr = 1'b1;
            end
            S_FLIP_LAST:  cmd.flip_wr = 1'b1;
            S_ADD:        cmd.mul_add = 1'b1;
            default:      cmd.latch   = accept;
        endcase
    end

endmodule

>>> rtl/rfpa_datapath.sv
// ----------------------------------------------------------------------------
// rfpa_datapath
// Bit store with per-word valid bits, set-bit counter, running total,
// multiplier and the result register.
// ----------------------------------------------------------------------------
module rfpa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rfpa_pkg::IDX_W-1:0]     first_index,
    input  logic [rfpa_pkg::IDX_W-1:0]     last_index,
    input  logic                           load_bit,
    input  logic [rfpa_pkg::AMT_W-1:0]     amount,
    input  rfpa_pkg::cmd_t                 cmd,
    output rfpa_pkg::stat_t                stat,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [rfpa_pkg::TOTAL_W-1:0]   total
);
    import rfpa_pkg::*;

    idx_t                 first_reg;
    idx_t                 last_reg;
    logic                 bit_reg;
    waddr_t               ptr_reg;
    waddr_t               wr_ptr_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [TOTAL_W-1:0]   rsp_total_reg;
    count_t               count_reg;
    count_t               count_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [WORD_COUNT-1:0] valid_reg;
    logic [WORD_COUNT-1:0] valid_next;
    logic                 rd_valid_reg;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    idx_t                 last_clamped;
    waddr_t               first_word;
    waddr_t               last_word;
    waddr_t               rd_addr;
    waddr_t               wr_addr;
    logic                 rd_en;
    logic                 wr_en;
    word_t                ram_rdata;
    word_t                rd_word;
    word_t                wr_data;
    word_t                mask;
    word_t                load_word;
    bitpos_t              lo;
    bitpos_t              hi;
    bitpos_t              bit_pos;
    wcount_t              mask_ones;
    wcount_t              hit_ones;

    assign last_clamped = (CMP_W'(last_index) >= CMP_W'(ARRAY_BITS))
                          ? IDX_W'(ARRAY_BITS - 1) : last_index;

    assign stat.load_ok     = CMP_W'(first_index) < CMP_W'(ARRAY_BITS);
    assign stat.flip_ok     = stat.load_ok && (first_index <= last_clamped);
    assign stat.at_last     = (ptr_reg == last_word);
    assign stat.rsp_blocked = rsp_valid_reg && rsp_stall;

    assign first_word = word_of(first_reg);
    assign last_word  = word_of(last_reg);
    assign bit_pos    = first_reg[BIT_W-1:0];

    assign rd_en   = cmd.load_rd || cmd.flip_rd;
    assign rd_addr = cmd.flip_rd ? ptr_reg : first_word;
    assign wr_en   = cmd.load_wr || cmd.flip_wr;
    assign wr_addr = cmd.flip_wr ? wr_ptr_reg : first_word;
    assign rd_word = rd_valid_reg ? ram_rdata : '0;

    assign lo        = (wr_ptr_reg == first_word) ? first_reg[BIT_W-1:0] : '0;
    assign hi        = (wr_ptr_reg == last_word) ? last_reg[BIT_W-1:0] : '1;
    assign mask      = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
    assign mask_ones = wcount_t'(hi) - wcount_t'(lo) + wcount_t'(1);
    assign hit_ones  = pop_word(rd_word & mask);

    always_comb
    begin
        load_word          = rd_word;
        load_word[bit_pos] = bit_reg;
    end

    assign wr_data = cmd.flip_wr ? (rd_word ^ mask) : load_word;

    rfpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.flip_wr)
        begin
            count_next = count_reg + count_t'(mask_ones) - (count_t'(hit_ones) << 1);
        end
        else if (cmd.load_wr)
        begin
            if (rd_word[bit_pos] && !bit_reg)
            begin
                count_next = count_reg - count_t'(1);
            end
            else if (!rd_word[bit_pos] && bit_reg)
            begin
                count_next = count_reg + count_t'(1);
            end
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (cmd.add_amount)
        begin
            total_next = total_reg + TOTAL_W'(amount);
        end
        else if (cmd.mul_add)
        begin
            total_next = total_reg + TOTAL_W'(prod_reg);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.report)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            first_reg <= first_index;
            last_reg  <= last_clamped;
            bit_reg   <= load_bit;
            ptr_reg   <= word_of(first_index);
        end
        else if (cmd.flip_rd)
        begin
            ptr_reg <= ptr_reg + waddr_t'(1);
        end
        if (cmd.flip_rd)
        begin
            wr_ptr_reg <= ptr_reg;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.mul_capture)
        begin
            prod_reg <= PROD_W'(count_reg) * PROD_W'(amount);
        end
        if (cmd.report)
        begin
            rsp_total_reg <= total_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign total     = rsp_total_reg;

endmodule

>>> rtl/range_flip_popcount_accumulator.sv
// ----------------------------------------------------------------------------
// range_flip_popcount_accumulator
// Bit array with a live set-bit count and a 64-bit running total.
// ----------------------------------------------------------------------------
// Add and report words leave the sequencer idle; a report result is registered and
// shows in the cycle after its word is accepted, and it may wait while new
// words are taken. A load reads the addressed word and writes it back. A
// count-times-scale add fills the multiplier register, then adds it in. A
// range flip rewrites each spanned word in turn through the single read port.
// Reset is asynchronous; store valid bits make the whole array read as zero.
// ----------------------------------------------------------------------------
module range_flip_popcount_accumulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [rfpa_pkg::KIND_W-1:0]    kind,
    input  logic [rfpa_pkg::IDX_W-1:0]     first_index,
    input  logic [rfpa_pkg::IDX_W-1:0]     last_index,
    input  logic                           load_bit,
    input  logic [rfpa_pkg::AMT_W-1:0]     amount,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [rfpa_pkg::TOTAL_W-1:0]   total
);
    import rfpa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .kind      (kind),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rfpa_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .first_index (first_index),
        .last_index  (last_index),
        .load_bit    (load_bit),
        .amount      (amount),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .total       (total)
    );

endmodule

>>> rtl/rfpa_checker.sv
// ----------------------------------------------------------------------------
// rfpa_checker
// Port-level checks of the range flip popcount accumulator.
// ----------------------------------------------------------------------------
module rfpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_stall,
    input logic [rfpa_pkg::KIND_W-1:0]    kind,
    input logic [rfpa_pkg::IDX_W-1:0]     first_index,
    input logic [rfpa_pkg::IDX_W-1:0]     last_index,
    input logic                           load_bit,
    input logic [rfpa_pkg::AMT_W-1:0]     amount,
    input logic                           rsp_valid,
    input logic                           rsp_stall,
    input logic [rfpa_pkg::TOTAL_W-1:0]   total
);
    import rfpa_pkg::*;

    logic accept;

    assign accept = req_valid && !req_stall;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(total)))
        else $error("stalled result word changed");

    a_report_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_REPORT)) |=> rsp_valid)
        else $error("accepted report gave no result word");

    a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_MUL)) |=> req_stall)
        else $error("multiply-accumulate did not hold off the next word");

    a_unknown_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind != KIND_LOAD) && (kind != KIND_FLIP) && (kind != KIND_MUL))
        |=> (!req_stall || (rsp_valid && rsp_stall)))
        else $error("single-cycle word left the block busy");

endmodule

bind range_flip_popcount_accumulator rfpa_checker u_rfpa_checker (.*);
